>>> rtl/circular_wrapping_ramp_smoother_defines.svh
// ----------------------------------------------------------------------------
// Circular wrapping ramp smoother: assertion macros
// Shared helpers for the concurrent checks at the end of the RTL modules.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_WRAPPING_RAMP_SMOOTHER_DEFINES_SVH
`define CIRCULAR_WRAPPING_RAMP_SMOOTHER_DEFINES_SVH

// Check sampled on clk_i and switched off while rst_ni is low.
`define CWRS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check sampled on clk_i that must also hold while reset is applied.
`define CWRS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/cwrs_pkg.sv
// ----------------------------------------------------------------------------
// Circular wrapping ramp smoother: package
// Widths, reset values, register indexes, state types and divider handshake.
// ----------------------------------------------------------------------------
package cwrs_pkg;

  // Default field widths
  localparam int unsigned DATA_WIDTH_DEF  = 32;
  localparam int unsigned COUNT_WIDTH_DEF = 24;

  // Extra fraction bits carried by the level and slope (Q16.16 -> Q16.32)
  localparam int unsigned FRAC_BITS = 16;

  // Configuration register widths and reset values
  localparam int unsigned PERIOD_WIDTH = 24;
  localparam int unsigned CFG_IDX_W    = 2;

  localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET     = 24'd1;
  localparam logic [31:0]             RANGE_LOW_RESET  = 32'd0;
  localparam logic [31:0]             RANGE_HIGH_RESET = 32'd23592960;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD     = 2'd0,
    CFG_RANGE_LOW  = 2'd1,
    CFG_RANGE_HIGH = 2'd2
  } cwrs_cfg_e;

  // Sequencer states of the top level
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TWRAP_GO,
    ST_TWRAP_WAIT,
    ST_PRIME,
    ST_EMIT,
    ST_LWRAP_GO,
    ST_LWRAP_WAIT,
    ST_DIFF,
    ST_ABS,
    ST_FOLD,
    ST_SLOPE_WAIT
  } cwrs_state_e;

  // States of the bit-serial divider
  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_ABS,
    DIV_RUN,
    DIV_FIX
  } cwrs_div_state_e;

  typedef struct packed {
    logic start;
    logic negate;
  } cwrs_div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cwrs_div_sts_t;

endpackage

>>> rtl/cwrs_div.sv
// ----------------------------------------------------------------------------
// Circular wrapping ramp smoother: bit-serial divider
// Restoring divider taking one quotient bit per cycle. Gives the quotient
// rounded toward zero and the remainder with the sign of the divisor.
// ----------------------------------------------------------------------------
`include "circular_wrapping_ramp_smoother_defines.svh"

module cwrs_div #(
  parameter int unsigned NumWidth = cwrs_pkg::DATA_WIDTH_DEF + cwrs_pkg::FRAC_BITS + 1,
  parameter int unsigned DvsWidth = cwrs_pkg::DATA_WIDTH_DEF + 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cwrs_pkg::cwrs_div_req_t       req_i,
  input  logic signed [NumWidth-1:0]    dividend_i,
  input  logic        [DvsWidth-1:0]    divisor_i,
  output cwrs_pkg::cwrs_div_sts_t       sts_o,
  output logic        [NumWidth-1:0]    quot_o,
  output logic        [DvsWidth-1:0]    rem_o
);
  import cwrs_pkg::*;

  localparam int unsigned CntWidth = (NumWidth > 1) ? $clog2(NumWidth) : 1;

  cwrs_div_state_e       state_q, state_d;
  logic                  done_q, done_d;
  logic [NumWidth-1:0]   acc_q, acc_d;
  logic [DvsWidth-1:0]   rem_q, rem_d;
  logic [DvsWidth-1:0]   dvs_q, dvs_d;
  logic                  neg_q, neg_d;
  logic [CntWidth-1:0]   cnt_q, cnt_d;

  logic [DvsWidth:0]     rem_shift;
  logic [DvsWidth+1:0]   trial;
  logic                  ge;

  always_comb begin
    rem_shift = {rem_q, acc_q[NumWidth-1]};
    trial     = {1'b0, rem_shift} - {2'b00, dvs_q};
    ge        = ~trial[DvsWidth+1];

    state_d = state_q;
    done_d  = 1'b0;
    acc_d   = acc_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    neg_d   = neg_q;
    cnt_d   = cnt_q;

    unique case (state_q)
      DIV_IDLE: begin
        if (req_i.start) begin
          acc_d   = dividend_i;
          neg_d   = req_i.negate;
          dvs_d   = divisor_i;
          state_d = DIV_ABS;
        end
      end
      DIV_ABS: begin
        // Work on the magnitude; the sign is folded into neg.
        if (acc_q[NumWidth-1]) begin
          acc_d = -acc_q;
          neg_d = ~neg_q;
        end
        rem_d   = '0;
        cnt_d   = CntWidth'(NumWidth - 1);
        state_d = DIV_RUN;
      end
      DIV_RUN: begin
        rem_d = ge ? trial[DvsWidth-1:0] : rem_shift[DvsWidth-1:0];
        acc_d = {acc_q[NumWidth-2:0], ge};
        cnt_d = cnt_q - CntWidth'(1);
        if (cnt_q == '0) begin
          state_d = DIV_FIX;
        end
      end
      DIV_FIX: begin
        // A negative dividend or a negate request (not both) negates the quotient
        // and, when it is not zero, reflects the remainder to keep it non-negative.
        if (neg_q) begin
          acc_d = -acc_q;
          if (rem_q != '0) begin
            rem_d = dvs_q - rem_q;
          end
        end
        done_d  = 1'b1;
        state_d = DIV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
    cnt_q <= cnt_d;
  end

  assign sts_o.busy = (state_q != DIV_IDLE);
  assign sts_o.done = done_q;
  assign quot_o     = acc_q;
  assign rem_o      = rem_q;

  `CWRS_ASSERT(a_div_start_idle, req_i.start |-> state_q == DIV_IDLE, "divider started while busy")
  `CWRS_ASSERT(a_div_done_pulse, done_q |=> !done_q, "divider done held for more than one cycle")
  `CWRS_ASSERT(a_div_rem_below, done_q |-> rem_q < dvs_q, "divider remainder not below divisor")

endmodule

>>> rtl/circular_wrapping_ramp_smoother.sv
// Output: a level beat is offered after its target beat is taken and passes the target wrap,
//   the prime step and the emit step, which waits while the output register is full.
// Input: a new target beat is taken only back in idle, after the level wrap and, when the
//   countdown expires, the slope division; all divisions share the single bit-serial divider.
// Reset: rst_ni is asynchronous and active low; it restores the register defaults and
//   leaves the ramp unprimed, so the first target after reset loads the level.
// ----------------------------------------------------------------------------
// Circular wrapping ramp smoother
// Ramps a Q16.16 level linearly toward each target around a circular range.
// ----------------------------------------------------------------------------
`include "circular_wrapping_ramp_smoother_defines.svh"

module circular_wrapping_ramp_smoother #(
  parameter int unsigned COUNT_WIDTH = cwrs_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned DATA_WIDTH  = cwrs_pkg::DATA_WIDTH_DEF,
  localparam int unsigned CfgWidth   =
    (DATA_WIDTH > cwrs_pkg::PERIOD_WIDTH) ? DATA_WIDTH : cwrs_pkg::PERIOD_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port
  input  logic                              cfg_we_i,
  input  logic [cwrs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CfgWidth-1:0]               cfg_data_i,
  // Target channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [DATA_WIDTH-1:0]      target_i,
  // Level channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [DATA_WIDTH-1:0]      level_o
);
  import cwrs_pkg::*;

  // The level and slope carry FRAC_BITS more fraction bits than the ports.
  localparam int unsigned LevelWidth = DATA_WIDTH + FRAC_BITS;
  // The divider sees signed values one bit wider than the level, which
  // covers the level difference as well as the wrap offsets.
  localparam int unsigned NumWidth   = LevelWidth + 1;
  // The divisor is either the range span (positive, DATA_WIDTH+1 bits) or
  // the reloaded countdown.
  localparam int unsigned DvsWidth   =
    (DATA_WIDTH + 1 > COUNT_WIDTH) ? DATA_WIDTH + 1 : COUNT_WIDTH;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [PERIOD_WIDTH-1:0]       period_q, period_d;
  logic signed [DATA_WIDTH-1:0]  range_low_q, range_low_d;
  logic signed [DATA_WIDTH-1:0]  range_high_q, range_high_d;

  always_comb begin
    period_d     = period_q;
    range_low_d  = range_low_q;
    range_high_d = range_high_q;
    if (cfg_we_i) begin
      unique case (cwrs_cfg_e'(cfg_index_i))
        CFG_PERIOD:     period_d     = cfg_data_i[PERIOD_WIDTH-1:0];
        CFG_RANGE_LOW:  range_low_d  = cfg_data_i[DATA_WIDTH-1:0];
        CFG_RANGE_HIGH: range_high_d = cfg_data_i[DATA_WIDTH-1:0];
        default: begin
          // Writes to an unused index are dropped.
        end
      endcase
    end
  end

  // The span of the circle is kept in a register of its own so that the
  // fold compare does not sit behind a second subtractor. The user must
  // change configuration only while the block is idle (the block does not
  // enforce this); then the span is settled when the sequencer reads it.
  logic signed [DATA_WIDTH:0]    span_q, span_d;
  logic                          span_pos;
  logic [DvsWidth-1:0]           span_divisor;

  assign span_d       = {range_high_q[DATA_WIDTH-1], range_high_q}
                      - {range_low_q[DATA_WIDTH-1], range_low_q};
  assign span_pos     = !span_q[DATA_WIDTH] && (span_q != '0);
  assign span_divisor = DvsWidth'($unsigned(span_q));

  // --------------------------------------------------------------------------
  // Ramp state and working registers
  // --------------------------------------------------------------------------
  cwrs_state_e                   state_q, state_d;
  logic                          primed_q, primed_d;
  logic [COUNT_WIDTH-1:0]        count_q, count_d;
  logic signed [LevelWidth-1:0]  level_q, level_d;
  logic signed [LevelWidth-1:0]  slope_q, slope_d;
  logic signed [DATA_WIDTH-1:0]  tgt_raw_q, tgt_raw_d;
  logic signed [DATA_WIDTH-1:0]  tgt_hi_q, tgt_hi_d;
  logic signed [LevelWidth:0]    sum_q, sum_d;
  logic signed [LevelWidth:0]    diff_q, diff_d;
  logic [LevelWidth:0]           mag_q, mag_d;
  logic                          diff_neg_q, diff_neg_d;
  logic                          out_valid_q, out_valid_d;
  logic signed [DATA_WIDTH-1:0]  out_level_q, out_level_d;

  // --------------------------------------------------------------------------
  // Shared divider
  // --------------------------------------------------------------------------
  cwrs_div_req_t                 div_req;
  cwrs_div_sts_t                 div_sts;
  logic signed [NumWidth-1:0]    div_dividend;
  logic [DvsWidth-1:0]           div_divisor;
  logic [NumWidth-1:0]           div_quot;
  logic [DvsWidth-1:0]           div_rem;

  cwrs_div #(
    .NumWidth (NumWidth),
    .DvsWidth (DvsWidth)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .sts_o      (div_sts),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // --------------------------------------------------------------------------
  // Datapath helpers
  // --------------------------------------------------------------------------
  logic signed [NumWidth-1:0]    low_ext;
  logic signed [NumWidth-1:0]    tgt_offset;
  logic signed [NumWidth-1:0]    lvl_offset;
  logic [COUNT_WIDTH-1:0]        period_cnt;
  logic [COUNT_WIDTH-1:0]        reload;
  logic [LevelWidth:0]           alt;
  logic                          fold;

  // Both wraps work on whole units only: the bounds have no fraction bits
  // beyond Q16.16, so the extra fraction of the level passes straight by
  // and only the part above it is reduced modulo the span.
  assign low_ext    = NumWidth'(range_low_q);
  assign tgt_offset = NumWidth'(tgt_raw_q) - low_ext;
  assign lvl_offset = NumWidth'($signed(sum_q[LevelWidth:FRAC_BITS])) - low_ext;

  // A period of zero reloads the countdown as one.
  assign period_cnt = COUNT_WIDTH'(period_q);
  assign reload     = (period_cnt == '0) ? COUNT_WIDTH'(1) : period_cnt;

  // Going the other way round the circle covers span - |d|. A tie keeps
  // the direct way.
  assign alt  = $unsigned({span_q, {FRAC_BITS{1'b0}}}) - mag_q;
  assign fold = span_pos && (mag_q > alt);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    primed_d     = primed_q;
    count_d      = count_q;
    level_d      = level_q;
    slope_d      = slope_q;
    tgt_raw_d    = tgt_raw_q;
    tgt_hi_d     = tgt_hi_q;
    sum_d        = sum_q;
    diff_d       = diff_q;
    mag_d        = mag_q;
    diff_neg_d   = diff_neg_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_level_d  = out_level_q;
    div_req      = '0;
    div_dividend = tgt_offset;
    div_divisor  = span_divisor;
    in_ready_o   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        // A new target may come in while the previous level beat still
        // waits in the output register.
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          tgt_raw_d = target_i;
          state_d   = ST_TWRAP_GO;
        end
      end
      ST_TWRAP_GO: begin
        if (span_pos) begin
          div_req.start = 1'b1;
          state_d       = ST_TWRAP_WAIT;
        end else begin
          // An empty or inverted range maps everything onto the low bound.
          tgt_hi_d = range_low_q;
          state_d  = ST_PRIME;
        end
      end
      ST_TWRAP_WAIT: begin
        if (div_sts.done) begin
          tgt_hi_d = range_low_q + div_rem[DATA_WIDTH-1:0];
          state_d  = ST_PRIME;
        end
      end
      ST_PRIME: begin
        // The first target after reset becomes the level, and the
        // countdown is left to expire on this same beat.
        if (!primed_q) begin
          level_d  = {tgt_hi_q, {FRAC_BITS{1'b0}}};
          slope_d  = '0;
          count_d  = COUNT_WIDTH'(1);
          primed_d = 1'b1;
        end
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_level_d = level_q[LevelWidth-1:FRAC_BITS];
          sum_d       = {level_q[LevelWidth-1], level_q}
                      + {slope_q[LevelWidth-1], slope_q};
          state_d     = ST_LWRAP_GO;
        end
      end
      ST_LWRAP_GO: begin
        if (span_pos) begin
          div_req.start = 1'b1;
          div_dividend  = lvl_offset;
          state_d       = ST_LWRAP_WAIT;
        end else begin
          level_d = {range_low_q, {FRAC_BITS{1'b0}}};
          state_d = ST_DIFF;
        end
      end
      ST_LWRAP_WAIT: begin
        div_dividend = lvl_offset;
        if (div_sts.done) begin
          level_d = {range_low_q + div_rem[DATA_WIDTH-1:0], sum_q[FRAC_BITS-1:0]};
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: begin
        // A countdown of one (or zero) expires and starts a new segment.
        if (count_q[COUNT_WIDTH-1:1] == '0) begin
          count_d = reload;
          diff_d  = {tgt_hi_q[DATA_WIDTH-1], tgt_hi_q, {FRAC_BITS{1'b0}}}
                  - {level_q[LevelWidth-1], level_q};
          state_d = ST_ABS;
        end else begin
          count_d = count_q - COUNT_WIDTH'(1);
          state_d = ST_IDLE;
        end
      end
      ST_ABS: begin
        mag_d      = diff_q[LevelWidth] ? $unsigned(-diff_q) : $unsigned(diff_q);
        diff_neg_d = diff_q[LevelWidth];
        state_d    = ST_FOLD;
      end
      ST_FOLD: begin
        // When folded, the slope heads the other way round: alt with the
        // sign opposite to the direct difference.
        div_req.start  = 1'b1;
        div_req.negate = fold && !diff_neg_q;
        div_dividend   = fold ? $signed(alt) : diff_q;
        div_divisor    = DvsWidth'(count_q);
        state_d        = ST_SLOPE_WAIT;
      end
      ST_SLOPE_WAIT: begin
        div_divisor = DvsWidth'(count_q);
        if (div_sts.done) begin
          slope_d = div_quot[LevelWidth-1:0];
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q     <= PERIOD_RESET;
      range_low_q  <= RANGE_LOW_RESET[DATA_WIDTH-1:0];
      range_high_q <= RANGE_HIGH_RESET[DATA_WIDTH-1:0];
      state_q      <= ST_IDLE;
      primed_q     <= 1'b0;
      count_q      <= COUNT_WIDTH'(1);
      out_valid_q  <= 1'b0;
    end else begin
      period_q     <= period_d;
      range_low_q  <= range_low_d;
      range_high_q <= range_high_d;
      state_q      <= state_d;
      primed_q     <= primed_d;
      count_q      <= count_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    span_q      <= span_d;
    level_q     <= level_d;
    slope_q     <= slope_d;
    tgt_raw_q   <= tgt_raw_d;
    tgt_hi_q    <= tgt_hi_d;
    sum_q       <= sum_d;
    diff_q      <= diff_d;
    mag_q       <= mag_d;
    diff_neg_q  <= diff_neg_d;
    out_level_q <= out_level_d;
  end

  assign out_valid_o = out_valid_q;
  assign level_o     = out_level_q;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `CWRS_ASSERT_ALWAYS(a_count_nonzero, !rst_ni || count_q != '0, "countdown reached zero")
  `CWRS_ASSERT(a_out_from_emit, $rose(out_valid_o) |-> $past(state_q) == ST_EMIT, "level beat raised outside the emit step")
  `CWRS_ASSERT(a_done_expected, div_sts.done |-> (state_q == ST_TWRAP_WAIT || state_q == ST_LWRAP_WAIT || state_q == ST_SLOPE_WAIT), "divider result arrived while nobody waits for it")

endmodule

>>> test/circular_wrapping_ramp_smoother_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular wrapping ramp smoother: testbench
// Drives target beats through valid/ready with random gaps and stalls.
// Reprograms the period and the circular range between phases.
// A scoreboard holds its own ramp state and compares every level beat.
// ----------------------------------------------------------------------------
module circular_wrapping_ramp_smoother_test;
  import cwrs_pkg::*;

  localparam int unsigned DataWidth      = DATA_WIDTH_DEF;
  localparam int unsigned CountWidth     = COUNT_WIDTH_DEF;
  localparam int unsigned CfgDataWidth   = 32;
  // Long enough for the divider to finish a slope after the last level beat.
  localparam int unsigned SettleCycles   = 3 * DataWidth + 120;
  localparam int unsigned WatchdogLimit  = 4000;
  localparam int unsigned PhaseCount     = 12;
  localparam int unsigned ItemsPerPhase  = 34;
  // The index port is two bits wide but only three registers exist.
  localparam logic [CFG_IDX_W-1:0] CfgUnusedIndex = 2'd3;
  localparam logic [31:0] DegQ16_360 = 32'h0168_0000;
  localparam logic [31:0] DegQ16_180 = 32'h00B4_0000;
  localparam logic [31:0] DegQ16_90  = 32'h005A_0000;
  localparam logic [31:0] DegQ16_270 = 32'h010E_0000;
  localparam logic [31:0] DegQ16_10  = 32'h000A_0000;
  localparam logic [31:0] DegQ16_350 = 32'h015E_0000;
  localparam logic [31:0] DegQ16_5   = 32'h0005_0000;
  localparam logic [31:0] Q16Max     = 32'h7FFF_FFFF;
  localparam logic [31:0] Q16Min     = 32'h8000_0000;

  // --------------------------------------------------------------------------
  // Scoreboard: a private copy of the ramp state, updated on every accepted
  // target beat, and the queue of levels that the block still owes us.
  // --------------------------------------------------------------------------
  class ramp_level_predictor;
    logic [PERIOD_WIDTH-1:0] period;
    logic [DataWidth-1:0]    low_reg;
    logic [DataWidth-1:0]    high_reg;
    longint                  level_q32;
    longint                  slope_q32;
    logic [CountWidth-1:0]   countdown;
    bit                      primed;
    logic [DataWidth-1:0]    owed_levels[$];
    int                      mismatches;

    function new();
      period     = PERIOD_RESET;
      low_reg    = RANGE_LOW_RESET;
      high_reg   = RANGE_HIGH_RESET;
      level_q32  = 0;
      slope_q32  = 0;
      countdown  = 1;
      primed     = 0;
      mismatches = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    function int pending();
      return owed_levels.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CfgDataWidth-1:0] data);
      case (idx)
        CFG_PERIOD:     period   = data[PERIOD_WIDTH-1:0];
        CFG_RANGE_LOW:  low_reg  = data[DataWidth-1:0];
        CFG_RANGE_HIGH: high_reg = data[DataWidth-1:0];
        default: ;
      endcase
    endfunction

    // Folds x into [lo, hi); an empty or inverted range collapses to lo.
    function longint wrap_circular(longint x, longint lo, longint hi);
      longint span;
      longint rem;
      span = hi - lo;
      if (span <= 0) return lo;
      rem = (x - lo) % span;
      if (rem < 0) rem += span;
      return lo + rem;
    endfunction

    function void note_target(logic [DataWidth-1:0] target);
      longint lo;
      longint hi;
      longint span;
      longint goal;
      longint diff;
      longint mag;
      longint reload;
      logic [63:0] raw;
      lo   = longint'($signed(low_reg)) * 64'sd65536;
      hi   = longint'($signed(high_reg)) * 64'sd65536;
      span = hi - lo;
      goal = wrap_circular(longint'($signed(target)) * 64'sd65536, lo, hi);
      // The first beat after reset places the level on the target directly.
      if (!primed) begin
        level_q32 = goal;
        slope_q32 = 0;
        countdown = 1;
        primed    = 1;
      end
      raw = level_q32;
      owed_levels.push_back(raw[DataWidth+FRAC_BITS-1:FRAC_BITS]);
      level_q32 = wrap_circular(level_q32 + slope_q32, lo, hi);
      if (countdown <= 1) begin
        reload    = (period == 0) ? 64'sd1 : longint'(period);
        countdown = reload[CountWidth-1:0];
        diff      = goal - level_q32;
        mag       = (diff < 0) ? -diff : diff;
        // Go the short way round; an exact half keeps its sign.
        if (span > 0 && mag > span - mag) begin
          diff = (diff < 0) ? (span - mag) : -(span - mag);
        end
        slope_q32 = diff / reload;
      end else begin
        countdown = countdown - 1'b1;
      end
    endfunction

    task check_level(logic [DataWidth-1:0] got);
      logic [DataWidth-1:0] want;
      if (owed_levels.size() == 0) begin
        report($sformatf("level %h arrived with nothing outstanding", got));
        return;
      end
      want = owed_levels.pop_front();
      if (got !== want) report($sformatf("level got %h, want %h", got, want));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and every block input, all at known values from time zero.
  // --------------------------------------------------------------------------
  logic                     clk         = 1'b0;
  logic                     rst_n       = 1'b0;
  logic                     cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index   = CFG_PERIOD;
  logic [CfgDataWidth-1:0]  cfg_data    = '0;
  logic                     in_valid    = 1'b0;
  logic [DataWidth-1:0]     target      = '0;
  logic                     out_ready   = 1'b0;
  logic                     in_ready_o;
  logic                     out_valid_o;
  logic [DataWidth-1:0]     level_o;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int unsigned              send_idle_pct  = 0;
  int unsigned              recv_stall_pct = 0;
  int unsigned              quiet_cycles   = 0;

  // Current range as programmed, used to aim random targets.
  logic [DataWidth-1:0]     cur_low  = RANGE_LOW_RESET;
  logic [DataWidth-1:0]     cur_high = RANGE_HIGH_RESET;

  ramp_level_predictor sb;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  circular_wrapping_ramp_smoother i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .target_i    (target),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .level_o     (level_o)
  );

  // The receiver decides afresh every cycle whether to take a level beat.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor. Everything here is read straight after the edge, before any
  // nonblocking update lands, so it sees the values that the block sampled.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready_o) sb.note_target(target);
      if (out_valid_o && out_ready) sb.check_level(level_o);
    end
  end

  // Watchdog: a long stretch with no beat on any port means the block hung.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we || (in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WatchdogLimit) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offers one target beat, with random idle cycles in front of it, and
  // returns on the edge that accepts it with valid still high.
  task automatic send_target(input logic [DataWidth-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    target   <= value;
    do @(posedge clk); while (!in_ready_o);
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Leaves write enable high; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CfgDataWidth-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Registers are only touched once the block has gone quiet: every level
  // beat in, then enough cycles for a slope division still in flight.
  task automatic apply_config(input logic [PERIOD_WIDTH-1:0] period,
                              input logic [DataWidth-1:0] low,
                              input logic [DataWidth-1:0] high);
    stop_sending();
    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    // The upper data bits are dont-care for the period, so they get noise.
    write_reg(CFG_PERIOD, {8'($urandom_range(255)), period});
    write_reg(CFG_RANGE_LOW, low);
    write_reg(CFG_RANGE_HIGH, high);
    cfg_we   <= 1'b0;
    cur_low  = low;
    cur_high = high;
  endtask

  function automatic logic [PERIOD_WIDTH-1:0] pick_period();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return PERIOD_WIDTH'($urandom_range(300, 16));
      default: return PERIOD_WIDTH'($urandom_range(8, 1));
    endcase
  endfunction

  // Mostly sensible ranges of a few hundred units, with the odd full,
  // empty, inverted, tiny or entirely random range thrown in.
  task automatic pick_range(output logic [DataWidth-1:0] low,
                            output logic [DataWidth-1:0] high);
    longint lo;
    case ($urandom_range(11))
      0: begin
        low  = Q16Min;
        high = Q16Max;
      end
      1: begin
        low  = $urandom;
        high = low;
      end
      2: begin
        low  = $urandom_range(32'h7FFF_FFFF, 32'h0000_0001);
        high = low - $urandom_range(32'h7FFF_FFFF, 32'h0000_0001);
        if ($signed(high) >= $signed(low)) high = low;
      end
      3: begin
        low  = $urandom;
        high = $urandom;
      end
      4: begin
        low  = $urandom_range(32'h0010_0000);
        high = low + $urandom_range(4, 1);
      end
      default: begin
        lo   = longint'($urandom_range(32'h07D0_0000)) - 64'sd65536000;
        low  = lo[DataWidth-1:0];
        high = DataWidth'(lo + longint'($urandom_range(32'h02D0_0000, 32'h0000_0100)));
      end
    endcase
  endtask

  // Targets sit inside the range, one lap either side of it, on its edges,
  // or anywhere at all.
  function automatic logic [DataWidth-1:0] pick_target();
    longint lo;
    longint hi;
    longint span;
    longint pick;
    lo   = longint'($signed(cur_low));
    hi   = longint'($signed(cur_high));
    span = hi - lo;
    if (span <= 0 || $urandom_range(4) == 0) return $urandom;
    case ($urandom_range(9))
      0:       pick = lo;
      1:       pick = hi - 1;
      2:       pick = hi;
      3:       pick = lo - 1;
      default: begin
        pick = lo + (longint'($urandom_range(65535)) * span) / 65536;
        pick = pick + span * (longint'($urandom_range(2)) - 1);
      end
    endcase
    return pick[DataWidth-1:0];
  endfunction

  initial begin
    logic [DataWidth-1:0] low;
    logic [DataWidth-1:0] high;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, starting on the reset configuration of one sample per
    // ramp and a range of 0 to 360. The first beat lands on the largest
    // target, which also primes the level.
    send_target(Q16Max);
    send_target(Q16Min);
    send_target('0);
    send_target('1);
    send_target(DegQ16_360);
    send_target(DegQ16_180);
    send_target(DegQ16_90);
    send_target(DegQ16_270);

    // Longer ramps, crossing the wrap point both ways.
    apply_config(4, RANGE_LOW_RESET, DegQ16_360);
    send_target(DegQ16_10);
    send_target(DegQ16_10);
    send_target(DegQ16_10);
    send_target(DegQ16_350);
    send_target(DegQ16_350);
    send_target(DegQ16_10);

    // A period of zero behaves as a period of one.
    apply_config('0, RANGE_LOW_RESET, DegQ16_360);
    send_target(DegQ16_180);
    send_target(DegQ16_5);

    // A write to the spare index must leave every register alone.
    stop_sending();
    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    write_reg(CfgUnusedIndex, $urandom);
    cfg_we <= 1'b0;
    send_target(DegQ16_90);

    // Empty range, then inverted range: everything collapses to the low bound.
    apply_config(2, DegQ16_5, DegQ16_5);
    send_target(DegQ16_90);
    send_target(Q16Max);
    apply_config(3, Q16Max, Q16Min);
    send_target(Q16Min);
    send_target('0);

    // Widest range with the longest period.
    apply_config('1, Q16Min, Q16Max);
    send_target(Q16Max);
    send_target(Q16Min);
    send_target('0);

    // Random phases, cycling through the idling patterns.
    for (int phase = 0; phase < PhaseCount; phase++) begin
      pick_range(low, high);
      apply_config(pick_period(), low, high);
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      for (int n = 0; n < ItemsPerPhase; n++) begin
        // Now and then hold off until the block has handed back every level.
        if ($urandom_range(49) == 0) begin
          stop_sending();
          wait_drained();
        end
        send_target(pick_target());
      end
    end

    stop_sending();
    recv_stall_pct = 0;
    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d levels never arrived", sb.pending()));
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
